/* rtl/core/mmeo_pkg.sv */
// shared constants, codes and control types for the matrix multiply block
`timescale 1ns / 1ps

package mmeo_pkg;

  localparam int MAX_DIM    = 16;
  localparam int ELEM_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int STORE_AW   = 2 * IDX_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MUL_W      = 2 * ELEM_WIDTH;

  // widths of the channel fields
  localparam int REQ_TYPE_W = 2;
  localparam int POS_W      = 4;
  localparam int VALUE_W    = 16;
  localparam int PROD_W     = 36;
  localparam int DIM_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_QUERY  = 2'd2
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_SIZE_ERR  = 2'd1,
    STAT_RANGE_ERR = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic             take;   // request accepted this cycle
    logic             issue;  // read one term pair
    logic [IDX_W-1:0] k;      // term index
    logic             emit;   // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             req_query;
    logic             req_err;
    logic [DIM_W-1:0] n_terms;
    logic             pipe_busy;
    logic             out_free;
  } stat_t;

endpackage

/* rtl/core/mmeo_if.sv */
// request, result and register write channels
`timescale 1ns / 1ps

interface mmeo_req_if
  import mmeo_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [REQ_TYPE_W-1:0]     req_type;
  logic [POS_W-1:0]          row_index;
  logic [POS_W-1:0]          col_index;
  logic signed [VALUE_W-1:0] elem_value;

  modport source (output valid, req_type, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, req_type, row_index, col_index, elem_value, output ready);
endinterface

interface mmeo_rsp_if
  import mmeo_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product_value;
  logic [DIM_W-1:0]         result_rows;
  logic [DIM_W-1:0]         result_cols;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, product_value, result_rows, result_cols, status, input ready);
  modport sink   (input valid, product_value, result_rows, result_cols, status, output ready);
endinterface

interface mmeo_cfg_if
  import mmeo_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DIM_W-1:0]     wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/core/mmeo_ctrl.sv */
// sequencer for loads and queries: accept, issue terms, flush, emit
`timescale 1ns / 1ps

module mmeo_ctrl
  import mmeo_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic             last_term;

  assign last_term = (DIM_W'(k_q) == (stat_i.n_terms - DIM_W'(1)));

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (req_valid_i && stat_i.req_query) begin
          state_d = stat_i.req_err ? ST_EMIT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_d = k_q + IDX_W'(1);
        if (last_term) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.k     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.take  = req_valid_i;
      end
      ST_ISSUE: cmd_o.issue = 1'b1;
      ST_FLUSH: ;
      ST_EMIT:  cmd_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

/* rtl/core/mmeo_dp.sv */
// datapath: size registers, element stores, shared multiply-accumulate, result register
`timescale 1ns / 1ps

module mmeo_dp
  import mmeo_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // register writes
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [DIM_W-1:0]          cfg_data_i,
  // request payload
  input  logic [REQ_TYPE_W-1:0]     req_type_i,
  input  logic [POS_W-1:0]          row_index_i,
  input  logic [POS_W-1:0]          col_index_i,
  input  logic signed [VALUE_W-1:0] elem_value_i,
  // result channel
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic signed [PROD_W-1:0]  product_value_o,
  output logic [DIM_W-1:0]          result_rows_o,
  output logic [DIM_W-1:0]          result_cols_o,
  output logic [STATUS_W-1:0]       status_o,
  // control
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [DIM_W-1:0] ar, ac, br, bc;

  // decode of the incoming request
  logic             mode_ba, size_err, in_range, load_ok, is_load_a, is_load_b;
  logic [DIM_W-1:0] rows_c, cols_c, terms_c;
  status_e          status_c;

  // latched query context
  logic             mode_ba_q;
  logic [DIM_W-1:0] rows_q, cols_q, terms_q;
  status_e          status_q;
  logic [IDX_W-1:0] row_q, col_q;

  // element stores
  logic [ELEM_WIDTH-1:0]        a_mem [STORE_DEPTH];
  logic [ELEM_WIDTH-1:0]        b_mem [STORE_DEPTH];
  logic [STORE_AW-1:0]          wr_addr, a_rd_addr, b_rd_addr;
  logic signed [ELEM_WIDTH-1:0] wr_elem;
  logic signed [ELEM_WIDTH-1:0] a_rd_q, b_rd_q;

  // mac pipeline
  logic                     rd_vld_q, mul_vld_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [PROD_W-1:0] acc_q;

  logic out_valid_q, out_free;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DIM_W'(1);
      a_cols_q <= DIM_W'(1);
      b_rows_q <= DIM_W'(1);
      b_cols_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_A_ROWS: a_rows_q <= cfg_data_i;
        CFG_A_COLS: a_cols_q <= cfg_data_i;
        CFG_B_ROWS: b_rows_q <= cfg_data_i;
        CFG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ar = clamp_dim(a_rows_q);
  assign ac = clamp_dim(a_cols_q);
  assign br = clamp_dim(b_rows_q);
  assign bc = clamp_dim(b_cols_q);

  // B*A takes priority when both orders fit
  always_comb begin
    mode_ba  = 1'b0;
    size_err = 1'b0;
    rows_c   = DIM_W'(1);
    cols_c   = DIM_W'(1);
    terms_c  = DIM_W'(1);
    if (ar == bc) begin
      mode_ba = 1'b1;
      rows_c  = br;
      cols_c  = ac;
      terms_c = bc;
    end else if (ac == br) begin
      rows_c  = ar;
      cols_c  = bc;
      terms_c = ac;
    end else begin
      size_err = 1'b1;
    end
  end

  assign in_range = (DIM_W'(row_index_i) < rows_c) && (DIM_W'(col_index_i) < cols_c);

  always_comb begin
    if (size_err) begin
      status_c = STAT_SIZE_ERR;
    end else if (!in_range) begin
      status_c = STAT_RANGE_ERR;
    end else begin
      status_c = STAT_OK;
    end
  end

  assign load_ok   = (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM);
  assign is_load_a = (req_type_i == REQ_LOAD_A) && load_ok;
  assign is_load_b = (req_type_i == REQ_LOAD_B) && load_ok;

  assign stat_o.req_query = (req_type_i == REQ_QUERY);
  assign stat_o.req_err   = (status_c != STAT_OK);
  assign stat_o.n_terms   = terms_q;
  assign stat_o.pipe_busy = rd_vld_q | mul_vld_q;
  assign stat_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && stat_o.req_query) begin
      mode_ba_q <= mode_ba;
      rows_q    <= rows_c;
      cols_q    <= cols_c;
      terms_q   <= terms_c;
      status_q  <= status_c;
      row_q     <= IDX_W'(row_index_i);
      col_q     <= IDX_W'(col_index_i);
    end
  end

  // stores: one write port, one registered read port each
  assign wr_addr = {IDX_W'(row_index_i), IDX_W'(col_index_i)};
  assign wr_elem = ELEM_WIDTH'(elem_value_i);

  always_comb begin
    if (mode_ba_q) begin
      a_rd_addr = {cmd_i.k, col_q};
      b_rd_addr = {row_q, cmd_i.k};
    end else begin
      a_rd_addr = {row_q, cmd_i.k};
      b_rd_addr = {cmd_i.k, col_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_load_a) begin
      a_mem[wr_addr] <= wr_elem;
    end
    if (cmd_i.issue) begin
      a_rd_q <= a_mem[a_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_load_b) begin
      b_mem[wr_addr] <= wr_elem;
    end
    if (cmd_i.issue) begin
      b_rd_q <= b_mem[b_rd_addr];
    end
  end

  // read -> multiply -> accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
    if (cmd_i.take) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + PROD_W'(prod_q);
    end
  end

  // result register
  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      product_value_o <= (status_q == STAT_OK) ? acc_q : '0;
      result_rows_o   <= rows_q;
      result_cols_o   <= cols_q;
      status_o        <= status_q;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

/* rtl/core/matrix_multiply_either_order.sv */
// top level of the either-order integer matrix multiplier
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    req_type, row_index, col_index, elem_value
//   rsp_o    out  valid/ready    product_value, result_rows, result_cols, status
//   cfg_i    in   valid/ready    reg_index, wr_data (always ready)
//
// a load is written to its store when it is accepted; a query accepts, reads n term pairs
// (n being the inner dimension) through the single shared multiply-accumulate, flushes
// the pipe and emits the result
// a query with a size or range error skips the terms and goes from accept straight to emit
// one request is worked at a time; a waiting result holds a query in emit, not loads
// reset sets all four size registers to 1; the element stores are not cleared
`timescale 1ns / 1ps

module matrix_multiply_either_order
  import mmeo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mmeo_req_if.sink    req_i,
  mmeo_rsp_if.source  rsp_o,
  mmeo_cfg_if.sink    cfg_i
);

  cmd_t  cmd;
  stat_t stat;
  logic  req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  mmeo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mmeo_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_idx_i       (cfg_i.reg_index),
    .cfg_data_i      (cfg_i.wr_data),
    .req_type_i      (req_i.req_type),
    .row_index_i     (req_i.row_index),
    .col_index_i     (req_i.col_index),
    .elem_value_i    (req_i.elem_value),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .product_value_o (rsp_o.product_value),
    .result_rows_o   (rsp_o.result_rows),
    .result_cols_o   (rsp_o.result_cols),
    .status_o        (rsp_o.status),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
